// ----- hdl/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// shared types and constants of the priority task table
// ----------------------------------------------------------------------------
`default_nettype none
package ptt_pkg;

    localparam int TASK_SLOTS_DEF    = 1024;
    localparam int PRIORITY_BITS_DEF = 32;
    localparam int OWNER_BITS_DEF    = 16;

    localparam int PRIO_MAX_W  = 64;
    localparam int OWNER_MAX_W = 32;
    localparam int IDX_MAX_W   = 16;
    localparam int TASK_ID_W   = 10;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_EDIT   = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_EXEC   = 2'd3;

    // table write broadcast to every cell
    typedef struct packed {
        logic                   en;
        logic [1:0]             mode;
        logic [TASK_ID_W-1:0]   task_id;
        logic [PRIO_MAX_W-1:0]  prio;
        logic [OWNER_MAX_W-1:0] owner;
    } ptt_cmd_t;

    // clear of the executed slot
    typedef struct packed {
        logic                 en;
        logic [IDX_MAX_W-1:0] idx;
    } ptt_clr_t;

endpackage
`default_nettype wire

// ----- hdl/ptt_cell.sv -----
// ----------------------------------------------------------------------------
// ptt_cell
// one task slot plus one stage of the running maximum
// ----------------------------------------------------------------------------
`default_nettype none
module ptt_cell #(
    parameter int IDX = 0,
    parameter int PW  = 32,
    parameter int OW  = 16,
    parameter int IW  = 10
) (
    input  wire               clk,
    input  wire               rst_n,
    input  ptt_pkg::ptt_cmd_t cmd,
    input  ptt_pkg::ptt_clr_t clr,
    input  wire               hit_in,
    input  wire  [PW-1:0]     prio_in,
    input  wire  [OW-1:0]     owner_in,
    input  wire  [IW-1:0]     idx_in,
    output logic              hit_out,
    output logic [PW-1:0]     prio_out,
    output logic [OW-1:0]     owner_out,
    output logic [IW-1:0]     idx_out
);
    import ptt_pkg::*;

    localparam int TW = (IW > TASK_ID_W) ? IW : TASK_ID_W;

    logic          valid_reg, valid_next;
    logic [PW-1:0] prio_reg;
    logic [OW-1:0] owner_reg;
    logic          match, clr_match, take;

    assign match     = cmd.en && (TW'(cmd.task_id) == TW'(IDX));
    assign clr_match = clr.en && (clr.idx[IW-1:0] == IW'(IDX));
    // >= hands ties to the higher slot further down the chain
    assign take      = valid_reg && (!hit_in || prio_reg >= prio_in);

    always_comb
    begin
        valid_next = valid_reg;
        if (match)
        begin
            if (cmd.mode == MODE_ADD)
                valid_next = 1'b1;
            else if (cmd.mode == MODE_REMOVE)
                valid_next = 1'b0;
        end
        else if (clr_match)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_out   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_out   <= hit_in || take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (match && (cmd.mode == MODE_ADD || (cmd.mode == MODE_EDIT && valid_reg)))
            prio_reg <= cmd.prio[PW-1:0];
        if (match && cmd.mode == MODE_ADD)
            owner_reg <= cmd.owner[OW-1:0];
        if (take)
        begin
            prio_out  <= prio_reg;
            owner_out <= owner_reg;
            idx_out   <= IW'(IDX);
        end
        else
        begin
            prio_out  <= prio_in;
            owner_out <= owner_in;
            idx_out   <= idx_in;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ptt_chain.sv -----
// ----------------------------------------------------------------------------
// ptt_chain
// row of slot cells, the maximum ripples one cell per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module ptt_chain #(
    parameter int N  = 1024,
    parameter int PW = 32,
    parameter int OW = 16,
    parameter int IW = 10
) (
    input  wire               clk,
    input  wire               rst_n,
    input  ptt_pkg::ptt_cmd_t cmd,
    input  ptt_pkg::ptt_clr_t clr,
    output logic              best_hit,
    output logic [PW-1:0]     best_prio,
    output logic [OW-1:0]     best_owner,
    output logic [IW-1:0]     best_idx
);
    import ptt_pkg::*;

    logic          hit   [N+1];
    logic [PW-1:0] prio  [N+1];
    logic [OW-1:0] owner [N+1];
    logic [IW-1:0] idx   [N+1];

    assign hit[0]   = 1'b0;
    assign prio[0]  = '0;
    assign owner[0] = '0;
    assign idx[0]   = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            ptt_cell #(.IDX(g), .PW(PW), .OW(OW), .IW(IW)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .clr       (clr),
                .hit_in    (hit[g]),
                .prio_in   (prio[g]),
                .owner_in  (owner[g]),
                .idx_in    (idx[g]),
                .hit_out   (hit[g+1]),
                .prio_out  (prio[g+1]),
                .owner_out (owner[g+1]),
                .idx_out   (idx[g+1])
            );
        end
    endgenerate

    assign best_hit   = hit[N];
    assign best_prio  = prio[N];
    assign best_owner = owner[N];
    assign best_idx   = idx[N];

endmodule
`default_nettype wire

// ----- hdl/priority_task_table_unit.sv -----
// ----------------------------------------------------------------------------
// priority_task_table_unit
// task table with execute-highest-priority, one cell per task slot
// ----------------------------------------------------------------------------
// add, edit and remove are registered in the addressed cell; the next word is accepted right after
// execute-top: the maximum ripples through the cell chain one cell per cycle;
//   the scan waits while a result is pending; then the result is registered
// result appears on the output register the cycle after the scan ends
// reset clears every slot valid mark and the output valid flag, not the output data
`default_nettype none
module priority_task_table_unit #(
    parameter int TASK_SLOTS    = ptt_pkg::TASK_SLOTS_DEF,
    parameter int PRIORITY_BITS = ptt_pkg::PRIORITY_BITS_DEF,
    parameter int OWNER_BITS    = ptt_pkg::OWNER_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  mode,
    input  wire  [15:0] user_id,
    input  wire  [9:0]  task_id,
    input  wire  [31:0] priority_req,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        found,
    output logic [15:0] owner_id,
    output logic [9:0]  executed_task
);
    import ptt_pkg::*;

    localparam int IW = $clog2(TASK_SLOTS);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic          state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg;
    logic          found_reg;
    logic [15:0]   owner_reg;
    logic [9:0]    task_reg;

    logic          accept, scan_done;
    ptt_cmd_t      cmd;
    ptt_clr_t      clr;
    logic          best_hit;
    logic [PRIORITY_BITS-1:0] best_prio;
    logic [OWNER_BITS-1:0]    best_owner;
    logic [IW-1:0] best_idx;
    logic [OWNER_BITS+15:0]   owner_ext;
    logic [IW+9:0] idx_ext;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign scan_done = (state_reg == ST_SCAN) && (cnt_reg == IW'(TASK_SLOTS - 1))
                       && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd         = '0;
        cmd.en      = accept && (mode != MODE_EXEC);
        cmd.mode    = mode;
        cmd.task_id = task_id;
        cmd.prio    = PRIO_MAX_W'(priority_req);
        cmd.owner   = OWNER_MAX_W'(user_id);
        clr         = '0;
        clr.en      = scan_done && best_hit;
        clr.idx     = IDX_MAX_W'(best_idx);
    end

    ptt_chain #(.N(TASK_SLOTS), .PW(PRIORITY_BITS), .OW(OWNER_BITS), .IW(IW)) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .clr        (clr),
        .best_hit   (best_hit),
        .best_prio  (best_prio),
        .best_owner (best_owner),
        .best_idx   (best_idx)
    );

    assign owner_ext = {16'b0, best_owner};
    assign idx_ext   = {10'b0, best_idx};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == MODE_EXEC)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_IDLE;
                else if (cnt_reg != IW'(TASK_SLOTS - 1))
                    cnt_next = cnt_reg + 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (scan_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_done)
        begin
            found_reg <= best_hit;
            owner_reg <= best_hit ? owner_ext[15:0] : 16'd0;
            task_reg  <= best_hit ? idx_ext[9:0] : 10'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign owner_id      = owner_reg;
    assign executed_task = task_reg;

    // unused beyond the chain, kept for visibility of the winning key
    logic prio_unused;
    assign prio_unused = ^best_prio;

    a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !in_ready)
        else $error("word accepted during scan");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (owner_id == 16'd0 && executed_task == 10'd0))
        else $error("empty result carries data");

    a_done_leaves_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |=> (state_reg == ST_IDLE) && out_valid)
        else $error("scan end not registered");

    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_EXEC) |=> (state_reg == ST_SCAN) && (cnt_reg == '0))
        else $error("execute did not start scan");

endmodule
`default_nettype wire
